// ===== design/msh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msh_pkg
// Fixed constants of the streaming string hash: seed values, generator
// constants for the mixing table, field widths.
// ----------------------------------------------------------------------------
package msh_pkg;

	localparam int CHAR_W      = 8;
	localparam int HASH_W      = 32;
	localparam int HTYPE_W     = 3;
	localparam int SLICE_SIZE  = 256;

	localparam logic [HASH_W-1:0] SEED_ONE_INIT = 32'h7FED_7FED;
	localparam logic [HASH_W-1:0] SEED_TWO_INIT = 32'hEEEE_EEEE;

	// Mixing table generator: s = (s * LCG_MULT + LCG_INC) mod LCG_MOD
	localparam logic [31:0] LCG_START = 32'h0010_0001;
	localparam logic [31:0] LCG_MULT  = 32'd125;
	localparam logic [31:0] LCG_INC   = 32'd3;
	localparam logic [31:0] LCG_MOD   = 32'h002A_AAAB;

	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;
	localparam logic [HASH_W-1:0] SEED_TWO_INC = 32'd3;

endpackage : msh_pkg
`default_nettype wire

// ===== design/mpq_string_hash_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_string_hash_unit
// Streaming string hash: one key byte per transaction, upper-cased, mixed
// through a fixed generator table into two 32-bit seeds; the final byte
// returns the first seed as the hash and reloads both seeds.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload                    | dir
//  ---------+----------------------+----------------------------+-----
//  input    | in_valid / in_stall  | char_byte[7:0], last_char  | in
//  result   | out_valid / out_stall| hash_value[31:0]           | out
//  config   | cfg_valid / cfg_ready| cfg_data[2:0] (hash_type)  | in
//
//  One byte per cycle sustained while no final byte is held (see below). A
//  byte is held in the table read register (the mixing ROM has a registered
//  read port), then updates the seeds; a final byte's hash is then written
//  to the result register, from which it is offered.
//  Only final bytes stall the input: a final byte in the read register waits
//  while a previous hash is still held by out_stall.
//  Asynchronous reset restores the seeds and clears hash_type to 0; the
//  table is a constant ROM built at elaboration, so no fill pass is needed.
//  cfg_ready is always high; hash_type is sampled as each byte is taken.
//
module mpq_string_hash_unit #(
	parameter int NUM_HASH_TYPES = 5
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire  [msh_pkg::CHAR_W-1:0] char_byte,
	input  wire                        last_char,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic [msh_pkg::HASH_W-1:0] hash_value,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire  [msh_pkg::HTYPE_W-1:0] cfg_data
);
	import msh_pkg::*;

	localparam int TABLE_WORDS = NUM_HASH_TYPES * SLICE_SIZE;
	localparam int IDX_W       = $clog2(TABLE_WORDS);
	localparam logic [HTYPE_W-1:0] LAST_SLICE = HTYPE_W'(NUM_HASH_TYPES - 1);

	typedef logic [HASH_W-1:0] rom_t [TABLE_WORDS];

	// Word (t*256 + c) takes two generator draws; columns outer, slices inner.
	function automatic rom_t build_rom();
		rom_t        tbl;
		logic [31:0] s;
		logic [31:0] hi;
		s = LCG_START;
		for (int c = 0; c < SLICE_SIZE; c++) begin
			for (int k = 0; k < NUM_HASH_TYPES; k++) begin
				s  = (s * LCG_MULT + LCG_INC) % LCG_MOD;
				hi = s;
				s  = (s * LCG_MULT + LCG_INC) % LCG_MOD;
				tbl[k * SLICE_SIZE + c] = {hi[15:0], s[15:0]};
			end
		end
		return tbl;
	endfunction

	localparam rom_t MIX_ROM = build_rom();

	// configuration
	logic [HTYPE_W-1:0] hash_type_q;

	// read register stage
	logic               valid_s1;
	logic               last_s1;
	logic [CHAR_W-1:0]  char_s1;
	logic [HASH_W-1:0]  mix_s1;

	// seeds and result
	logic [HASH_W-1:0]  seed_one_q;
	logic [HASH_W-1:0]  seed_two_q;
	logic               out_valid_q;
	logic [HASH_W-1:0]  hash_q;

	logic               in_take;
	logic               advance;
	logic [CHAR_W-1:0]  char_up;
	logic [HTYPE_W-1:0] slice;
	logic [IDX_W-1:0]   rom_idx;
	logic [HTYPE_W+CHAR_W-1:0] idx_full;
	logic [HASH_W-1:0]  seed_one_nxt;
	logic [HASH_W-1:0]  seed_two_nxt;

	assign cfg_ready = 1'b1;

	// ASCII lower case only; everything else passes unchanged
	always_comb begin
		if (char_byte inside {[8'h61:8'h7A]}) begin
			char_up = char_byte - CASE_OFFSET;
		end else begin
			char_up = char_byte;
		end
	end

	// out-of-range hash types saturate to the last slice
	always_comb begin
		if (32'(hash_type_q) >= NUM_HASH_TYPES) begin
			slice = LAST_SLICE;
		end else begin
			slice = hash_type_q;
		end
	end

	assign idx_full = {slice, char_up};
	assign rom_idx  = idx_full[IDX_W-1:0];

	// A non-final byte always moves on; a final one needs the result slot.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	assign seed_one_nxt = mix_s1 ^ (seed_one_q + seed_two_q);
	assign seed_two_nxt = HASH_W'(char_s1) + seed_one_nxt + seed_two_q
		+ (seed_two_q << 5) + SEED_TWO_INC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_type_q <= '0;
			valid_s1    <= 1'b0;
			seed_one_q  <= SEED_ONE_INIT;
			seed_two_q  <= SEED_TWO_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				hash_type_q <= cfg_data;
			end
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				if (last_s1) begin
					seed_one_q <= SEED_ONE_INIT;
					seed_two_q <= SEED_TWO_INIT;
				end else begin
					seed_one_q <= seed_one_nxt;
					seed_two_q <= seed_two_nxt;
				end
			end
			if (advance && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: ROM read port and result word
	always_ff @(posedge clk) begin
		if (in_take) begin
			mix_s1  <= MIX_ROM[rom_idx];
			char_s1 <= char_up;
			last_s1 <= last_char;
		end
		if (advance && last_s1) begin
			hash_q <= seed_one_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule : mpq_string_hash_unit
`default_nettype wire

// ===== design/msh_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msh_checker
// Port-level checks for the string hash unit, bound to the top level.
// ----------------------------------------------------------------------------
module msh_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        last_char,
	input wire        out_valid,
	input wire        out_stall,
	input wire [31:0] hash_value
);

	// held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hash_value))
		else $error("hash changed while stalled");

	// input only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// final byte with a free result slot then offers its hash
	a_last_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_char ##1 !out_valid |=> out_valid)
		else $error("final byte produced no hash");

endmodule : msh_checker

bind mpq_string_hash_unit msh_checker u_msh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.last_char  (last_char),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.hash_value (hash_value)
);
`default_nettype wire

// ===== tb/mpq_string_hash_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_string_hash_unit_test
// Self-checking bench for the streaming string hash. Key bytes go in one
// transaction at a time; a tracker class keeps its own copy of the mixing
// table, the two seeds and hash_type, predicts each final-byte hash and
// compares it with what the unit returns. Directed strings first, then
// random strings over every hash_type setting, with random idle bursts on
// both channels.
// ----------------------------------------------------------------------------
module mpq_string_hash_unit_test;
	import msh_pkg::*;

	localparam int HTYPES = 5;

	// Bench clock, 10 ns period
	logic clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every input has a known value from time zero
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic [CHAR_W-1:0]   char_byte = '0;
	logic                last_char = 1'b0;
	logic                out_stall = 1'b0;
	logic                cfg_valid = 1'b0;
	logic [HTYPE_W-1:0]  cfg_data  = '0;
	logic                in_stall;
	logic                out_valid;
	logic [HASH_W-1:0]   hash_value;
	logic                cfg_ready;

	// Set for the final stretch of the run: no idling on either side
	bit calm = 1'b0;

	mpq_string_hash_unit #(
		.NUM_HASH_TYPES(HTYPES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_byte (char_byte),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hash_value(hash_value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Hash tracker: mirrors the unit's state and queues the hashes it owes.
	// ------------------------------------------------------------------------
	class hash_tracker;
		logic [HASH_W-1:0]  mix_words [HTYPES*SLICE_SIZE];
		logic [HASH_W-1:0]  acc_one;
		logic [HASH_W-1:0]  acc_two;
		logic [HTYPE_W-1:0] hash_type;
		logic [HASH_W-1:0]  hashes_due [$];
		int unsigned        errors;

		function new();
			logic [31:0] s;
			logic [31:0] hi;
			s = LCG_START;
			// Table walks column-major: per column, each slice takes two draws
			for (int col = 0; col < SLICE_SIZE; col++) begin
				for (int t = 0; t < HTYPES; t++) begin
					s  = (s * LCG_MULT + LCG_INC) % LCG_MOD;
					hi = s;
					s  = (s * LCG_MULT + LCG_INC) % LCG_MOD;
					mix_words[t*SLICE_SIZE + col] = {hi[15:0], s[15:0]};
				end
			end
			acc_one   = SEED_ONE_INIT;
			acc_two   = SEED_TWO_INIT;
			hash_type = '0;
			errors    = 0;
		endfunction

		function void set_hash_type(logic [HTYPE_W-1:0] v);
			hash_type = v;
		endfunction

		function void take_char(logic [CHAR_W-1:0] b, logic last);
			logic [CHAR_W-1:0] ch;
			int                slice;
			ch = b;
			if (b >= 8'h61 && b <= 8'h7A)
				ch = b - CASE_OFFSET;
			// Out-of-range types fold onto the last slice
			slice = (hash_type >= HTYPES) ? HTYPES - 1 : int'(hash_type);
			acc_one = mix_words[slice*SLICE_SIZE + ch] ^ (acc_one + acc_two);
			acc_two = {24'b0, ch} + acc_one + acc_two + (acc_two << 5) + SEED_TWO_INC;
			if (last) begin
				hashes_due.push_back(acc_one);
				acc_one = SEED_ONE_INIT;
				acc_two = SEED_TWO_INIT;
			end
		endfunction

		function void match_hash(logic [HASH_W-1:0] got);
			logic [HASH_W-1:0] want;
			if (hashes_due.size() == 0) begin
				$error("hash_value: expected none, got %h", got);
				errors++;
			end else begin
				want = hashes_due.pop_front();
				if (got !== want) begin
					$error("hash_value: expected %h, got %h", want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return hashes_due.size();
		endfunction
	endclass

	hash_tracker tracker = new();

	// Result monitor: sampled at the rising edge, where the handshake completes
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.match_hash(hash_value);
	end

	// Result-side back-pressure: random bursts of stalled cycles, none when calm
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (!calm && arst_n && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 8);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// One key byte transaction, with an optional idle burst ahead of it.
	// Payload is held steady while stalled.
	task automatic send_char(input logic [CHAR_W-1:0] b, input logic last);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 8);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		char_byte <= b;
		last_char <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.take_char(b, last);
	endtask

	// Stop sending and wait for every owed hash, then let a non-final byte
	// still in the read register settle into the seeds.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_hash_type(input logic [HTYPE_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_hash_type(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random key byte, weighted towards the case-folding boundaries
	function automatic logic [CHAR_W-1:0] pick_char();
		logic [CHAR_W-1:0] edges [8] = '{8'h60, 8'h61, 8'h7A, 8'h7B,
			8'h40, 8'h5B, 8'h00, 8'hFF};
		case ($urandom_range(0, 3))
			0: return CHAR_W'($urandom_range(8'h61, 8'h7A));
			1: return CHAR_W'($urandom_range(8'h41, 8'h5A));
			2: return CHAR_W'($urandom_range(0, 255));
			default: return edges[$urandom_range(0, 7)];
		endcase
	endfunction

	// Whole string of random length; mostly short, now and then long
	task automatic send_string(output int len);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
		for (int i = 0; i < len; i++)
			send_char(pick_char(), i == len - 1);
	endtask

	// Generous fixed limit: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [HTYPE_W-1:0] phase_types [8] = '{3'd4, 3'd7, 3'd1, 3'd5,
			3'd2, 3'd6, 3'd3, 3'd0};
		logic [CHAR_W-1:0]  mixed [8] = '{8'h60, 8'h61, 8'h7A, 8'h7B,
			8'h40, 8'h41, 8'h5A, 8'h5B};
		int                 sent;
		int                 len;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: hash_type left at its reset value first.
		// Single-byte strings at the byte extremes, zero byte included.
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);
		send_char(8'h80, 1'b1);
		// Lower and upper case must hash alike
		send_char(8'h61, 1'b0);
		send_char(8'h7A, 1'b1);
		send_char(8'h41, 1'b0);
		send_char(8'h5A, 1'b1);
		// Bytes either side of both letter ranges
		foreach (mixed[i])
			send_char(mixed[i], i == 7);
		// hash_type changed part-way through a string: the seeds carry over
		send_char(8'h7F, 1'b0);
		send_char(8'h01, 1'b0);
		drain();
		write_hash_type(3'd7);
		send_char(8'h62, 1'b0);
		send_char(8'hC3, 1'b1);
		drain();
		write_hash_type(3'd4);
		send_char(8'h00, 1'b1);
		send_char(8'hFE, 1'b1);

		// Random phases, one per hash_type value; each ends with a full drain
		// before the next write. The last phase runs without idling.
		foreach (phase_types[p]) begin
			drain();
			write_hash_type(phase_types[p]);
			calm = (p == 7);
			sent = 0;
			while (sent < 100) begin
				send_string(len);
				sent += len;
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule : mpq_string_hash_unit_test

// ===== files.f =====
design/msh_pkg.sv
design/mpq_string_hash_unit.sv
design/msh_checker.sv
tb/mpq_string_hash_unit_test.sv
